### rtl/core/wps_pkg.sv
// ============================================================================
// wps_pkg
// Shared types, constants and register codes of the waveform peak summarizer.
// ============================================================================
package wps_pkg;

    // Sizes
    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int SAMPLE_W     = 16;
    localparam int MAX_W        = SAMPLE_W - 1;
    localparam int SUM_W        = 32;
    localparam int FRAME_W      = 16;
    localparam int CNT_REG_W    = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int DIV_STEPS    = SUM_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_LEN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_LEN    = 2'd2;

    // Reset values of the registers
    localparam logic [CNT_REG_W-1:0] RST_CHANNEL_COUNT = 4'd1;
    localparam logic [FRAME_W-1:0]   RST_FINE_LEN      = 16'd256;
    localparam logic [FRAME_W-1:0]   RST_COARSE_LEN    = 16'd362;

    // Request and block kind codes
    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_FLUSH   = 1'b1;
    localparam logic KIND_FINE   = 1'b0;
    localparam logic KIND_COARSE = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [CH_W-1:0]            chan_index;
    } t_in_item;

    typedef struct packed {
        logic                       cache_kind;
        logic [CH_W-1:0]            out_channel;
        logic signed [SAMPLE_W-1:0] block_min;
        logic [MAX_W-1:0]           block_max;
        logic [SAMPLE_W-1:0]        abs_mean;
        logic                       last_out;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic            capture;     // take the input beat
        logic            upd;         // fold sample into both kinds
        logic            cnt_adv;     // advance frame counters, set emit flags
        logic            flush_flags; // set flags for a flush
        logic            load;        // read slot, start division
        logic            div_step;    // one quotient bit
        logic            out_load;    // write the output register
        logic            out_last;    // final result of this item
        logic [1:0]      clr;         // clear a kind
        logic            kind;
        logic [CH_W-1:0] ch;
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic            is_flush;
        logic            chan_ok;
        logic            chan_last;
        logic [1:0]      emit;
        logic [1:0]      clr_pend;
        logic            div_last;
        logic            out_free;
        logic [CH_W-1:0] nch_last;
    } t_ctl_sts;

endpackage

### rtl/core/wps_ctrl.sv
// ============================================================================
// wps_ctrl
// Sequencer: takes one item, folds it in, then walks the summaries to emit.
// ============================================================================
module wps_ctrl
    import wps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_UPDATE = 6'b000010,
        S_SELECT = 6'b000100,
        S_LOAD   = 6'b001000,
        S_DIV    = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic            r_kind, n_kind;
    logic [CH_W-1:0] r_ch, n_ch;

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_ch    = r_ch;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        o_cmd.ch   = r_ch;
        case (r_state)
            S_IDLE: begin
                n_kind = KIND_FINE;
                n_ch   = '0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (i_sts.is_flush) begin
                    o_cmd.flush_flags = 1'b1;
                    n_state           = S_SELECT;
                end else if (!i_sts.chan_ok) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.upd = 1'b1;
                    if (i_sts.chan_last) begin
                        o_cmd.cnt_adv = 1'b1;
                        n_state       = S_SELECT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SELECT: begin
                // emit this kind, or drop it (clearing if flagged) and move on
                if (i_sts.emit[r_kind]) begin
                    n_ch    = '0;
                    n_state = S_LOAD;
                end else begin
                    o_cmd.clr[r_kind] = i_sts.clr_pend[r_kind];
                    if (r_kind == KIND_FINE) begin
                        n_kind = KIND_COARSE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = (r_ch == i_sts.nch_last) &&
                                     ((r_kind == KIND_COARSE) || !i_sts.emit[1]);
                    if (r_ch == i_sts.nch_last) begin
                        o_cmd.clr[r_kind] = 1'b1;
                        if (r_kind == KIND_FINE) begin
                            n_kind  = KIND_COARSE;
                            n_state = S_SELECT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_FINE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_ch    <= n_ch;
        end
    end

endmodule

### rtl/core/wps_datapath.sv
// ============================================================================
// wps_datapath
// Config registers, per-channel accumulators, frame counters, serial divider
// and output register.
// ============================================================================
module wps_datapath
    import wps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  t_ctl_cmd              i_cmd,
    output t_ctl_sts              o_sts
);

    logic [CNT_REG_W-1:0] r_channel_count;
    logic [FRAME_W-1:0]   r_len [2];

    t_in_item r_in;

    logic signed [SAMPLE_W-1:0] r_min [2][MAX_CHANNELS];
    logic [MAX_W-1:0]           r_max [2][MAX_CHANNELS];
    logic [SUM_W-1:0]           r_sum [2][MAX_CHANNELS];
    logic [FRAME_W-1:0]         r_frames [2];
    logic [1:0]                 r_emit;
    logic [1:0]                 r_clr;

    logic [SUM_W-1:0]           r_quo;
    logic [FRAME_W-1:0]         r_rem;
    logic [FRAME_W-1:0]         r_dvsr;
    logic [DIV_CNT_W-1:0]       r_div_cnt;
    logic signed [SAMPLE_W-1:0] r_st_min;
    logic [MAX_W-1:0]           r_st_max;

    t_out_item r_out;
    logic      r_out_valid;

    logic [CH_W-1:0]     w_nch_last;
    logic [CH_W-1:0]     w_ch;
    logic [SAMPLE_W-1:0] w_mag;
    logic [FRAME_W-1:0]  w_sat [2];
    logic [1:0]          w_reach;
    logic [FRAME_W:0]    w_trial;
    logic                w_qbit;

    // Last channel of a frame, with out-of-range counts folded in
    always_comb begin
        if (r_channel_count == '0) begin
            w_nch_last = '0;
        end else if (r_channel_count > CNT_REG_W'(MAX_CHANNELS)) begin
            w_nch_last = CH_W'(MAX_CHANNELS - 1);
        end else begin
            w_nch_last = CH_W'(r_channel_count - 1'b1);
        end
    end

    // One read address: the sample's channel on update, the walk otherwise
    assign w_ch  = i_cmd.upd ? r_in.chan_index : i_cmd.ch;
    assign w_mag = r_in.sample_value[SAMPLE_W-1] ? SAMPLE_W'(-r_in.sample_value)
                                                 : SAMPLE_W'(r_in.sample_value);

    // Saturating frame advance and block-end test
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_sat[k]   = (r_frames[k] == '1) ? r_frames[k] : r_frames[k] + 1'b1;
            w_reach[k] = (w_sat[k] >= ((r_len[k] == '0) ? FRAME_W'(1) : r_len[k]));
        end
    end

    // Restoring division step
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_dvsr});

    assign o_sts.is_flush  = (r_in.req_type == REQ_FLUSH);
    assign o_sts.chan_ok   = (r_in.chan_index <= w_nch_last);
    assign o_sts.chan_last = (r_in.chan_index == w_nch_last);
    assign o_sts.emit      = r_emit;
    assign o_sts.clr_pend  = r_clr;
    assign o_sts.div_last  = (r_div_cnt == DIV_CNT_W'(1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.nch_last  = w_nch_last;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= RST_CHANNEL_COUNT;
            r_len[0]        <= RST_FINE_LEN;
            r_len[1]        <= RST_COARSE_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CNT_REG_W-1:0];
                REG_FINE_LEN:      r_len[0]        <= i_cfg_data[FRAME_W-1:0];
                REG_COARSE_LEN:    r_len[1]        <= i_cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the accepted input beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
    end

    // Accumulators, frame counters and emit flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                for (int c = 0; c < MAX_CHANNELS; c++) begin
                    r_min[k][c] <= '0;
                    r_max[k][c] <= '0;
                    r_sum[k][c] <= '0;
                end
                r_frames[k] <= '0;
            end
            r_emit <= '0;
            r_clr  <= '0;
        end else begin
            for (int k = 0; k < 2; k++) begin
                if (i_cmd.upd) begin
                    if (r_in.sample_value < r_min[k][w_ch]) begin
                        r_min[k][w_ch] <= r_in.sample_value;
                    end
                    if (r_in.sample_value > $signed({1'b0, r_max[k][w_ch]})) begin
                        r_max[k][w_ch] <= r_in.sample_value[MAX_W-1:0];
                    end
                    r_sum[k][w_ch] <= r_sum[k][w_ch] + SUM_W'(w_mag);
                end
                if (i_cmd.cnt_adv) begin
                    r_frames[k] <= w_sat[k];
                    r_emit[k]   <= w_reach[k];
                    r_clr[k]    <= w_reach[k];
                end
                if (i_cmd.flush_flags) begin
                    r_emit[k] <= (r_frames[k] != '0);
                    r_clr[k]  <= 1'b1;
                end
                if (i_cmd.clr[k]) begin
                    for (int c = 0; c < MAX_CHANNELS; c++) begin
                        r_min[k][c] <= '0;
                        r_max[k][c] <= '0;
                        r_sum[k][c] <= '0;
                    end
                    r_frames[k] <= '0;
                end
            end
        end
    end

    // Serial divider: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.load) begin
            r_div_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo    <= r_sum[i_cmd.kind][w_ch];
            r_rem    <= '0;
            r_dvsr   <= r_frames[i_cmd.kind];
            r_st_min <= r_min[i_cmd.kind][w_ch];
            r_st_max <= r_max[i_cmd.kind][w_ch];
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], w_qbit};
            r_rem <= w_qbit ? FRAME_W'(w_trial - {1'b0, r_dvsr}) : w_trial[FRAME_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.cache_kind  <= i_cmd.kind;
            r_out.out_channel <= i_cmd.ch;
            r_out.block_min   <= r_st_min;
            r_out.block_max   <= r_st_max;
            r_out.abs_mean    <= r_quo[SAMPLE_W-1:0];
            r_out.last_out    <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while a beat waits");

    a_min_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.block_min[SAMPLE_W-1] || (r_out.block_min == '0)))
        else $error("block minimum above zero");

    a_clr_fine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr[0] |=> (r_frames[0] == '0))
        else $error("fine frame counter not cleared");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_div_cnt == DIV_CNT_W'(DIV_STEPS)) && (r_dvsr != '0))
        else $error("division started badly or with zero frames");
`endif

endmodule

### rtl/core/waveform_peak_summarizer.sv
// Each item is captured, then folded in; a frame end or a flush then checks each
// block length in turn. A block end emits up to 8 summaries per block length, each
// taking a load, 32 divider steps and the write to the output register.
// Results leave through an output register, so the next item is taken while the
// final summary still waits. Reset (synchronous, active low) clears all sums and counters.
// ============================================================================
// waveform_peak_summarizer
// Min, max and mean-absolute decimation of an interleaved audio stream at a
// fine and a coarse block length.
// ============================================================================
module waveform_peak_summarizer
    import wps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    // Sequencer
    wps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Storage and arithmetic
    wps_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the waveform peak summarizer. Sample and flush beats
// are sent under random gaps and output stalls. An in-bench predictor keeps the
// per-channel min, max and abs sums of both block lengths. Every summary the
// block emits is checked field by field against the oldest predicted one.
// ============================================================================
module tb;
    import wps_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int TAIL_CYCLES   = 600;
    localparam int MAX_REPORTS   = 40;
    localparam int N_PHASES      = 9;
    localparam int PHASE_ITEMS   = 21;
    localparam int SLOTS         = 2 * MAX_CHANNELS;

    // Index with no register behind it; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;

    waveform_peak_summarizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Predictor state: slot = channel * 2 + kind
    logic signed [SAMPLE_W-1:0] blk_min     [SLOTS];
    logic signed [SAMPLE_W-1:0] blk_max     [SLOTS];
    logic [SUM_W-1:0]           blk_abs_sum [SLOTS];
    logic [FRAME_W-1:0]         blk_frames  [2];
    logic [CNT_REG_W-1:0]       cfg_channels;
    logic [FRAME_W-1:0]         cfg_fine_len;
    logic [FRAME_W-1:0]         cfg_coarse_len;

    t_out_item   pending_summaries [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          calm = 1'b0;

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int live_channels();
        if (cfg_channels == 0) return 1;
        if (cfg_channels > MAX_CHANNELS) return MAX_CHANNELS;
        return int'(cfg_channels);
    endfunction

    function automatic logic [FRAME_W-1:0] block_len(input logic kind);
        logic [FRAME_W-1:0] len;
        len = (kind == KIND_COARSE) ? cfg_coarse_len : cfg_fine_len;
        return (len == 0) ? FRAME_W'(1) : len;
    endfunction

    task automatic clear_kind(input logic kind);
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            blk_min[ch * 2 + kind]     = '0;
            blk_max[ch * 2 + kind]     = '0;
            blk_abs_sum[ch * 2 + kind] = '0;
        end
        blk_frames[kind] = '0;
    endtask

    task automatic reset_summaries();
        cfg_channels   = RST_CHANNEL_COUNT;
        cfg_fine_len   = RST_FINE_LEN;
        cfg_coarse_len = RST_COARSE_LEN;
        clear_kind(KIND_FINE);
        clear_kind(KIND_COARSE);
    endtask

    // Queue one summary per live channel if the kind holds any frame, then clear it
    task automatic emit_kind(input logic kind, inout int n);
        t_out_item        s;
        int               slot;
        logic [SUM_W-1:0] quot;
        if (blk_frames[kind] != 0) begin
            for (int ch = 0; ch < live_channels(); ch++) begin
                slot          = ch * 2 + kind;
                quot          = blk_abs_sum[slot] / {{(SUM_W - FRAME_W){1'b0}}, blk_frames[kind]};
                s.cache_kind  = kind;
                s.out_channel = CH_W'(ch);
                s.block_min   = blk_min[slot];
                s.block_max   = blk_max[slot][MAX_W-1:0];
                s.abs_mean    = quot[SAMPLE_W-1:0];
                s.last_out    = 1'b0;
                pending_summaries = {pending_summaries, s};
                n++;
            end
        end
        clear_kind(kind);
    endtask

    // Fold one accepted beat into the state and queue the summaries it causes
    task automatic summarize_item(input t_in_item it);
        int               n;
        int               v;
        int               ch;
        int               nch;
        int               slot;
        logic [SUM_W-1:0] mag;
        n = 0;
        if (it.req_type == REQ_FLUSH) begin
            emit_kind(KIND_FINE, n);
            emit_kind(KIND_COARSE, n);
        end else begin
            ch  = int'(it.chan_index);
            nch = live_channels();
            if (ch < nch) begin
                v   = int'(it.sample_value);
                mag = (v < 0) ? -v : v;
                for (int k = 0; k < 2; k++) begin
                    slot = ch * 2 + k;
                    if (v < blk_min[slot]) blk_min[slot] = SAMPLE_W'(v);
                    if (v > blk_max[slot]) blk_max[slot] = SAMPLE_W'(v);
                    blk_abs_sum[slot] = blk_abs_sum[slot] + mag;
                end
                // last channel closes the frame for both lengths
                if (ch == nch - 1) begin
                    for (int k = 0; k < 2; k++) begin
                        blk_frames[k] = blk_frames[k] + 1'b1;
                        if (blk_frames[k] == 0 || blk_frames[k] >= block_len(k[0])) begin
                            if (blk_frames[k] == 0) blk_frames[k] = '1;
                            emit_kind(k[0], n);
                        end
                    end
                end
            end
        end
        // mark the final summary of this beat
        if (n > 0)
            pending_summaries[pending_summaries.size() - 1].last_out = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    always @(posedge i_clk) begin : check_summary
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_summaries.size() == 0) begin
                report_mismatch($sformatf("summary with nothing pending: %h", o_out_data));
            end else begin
                want = pending_summaries.pop_front();
                check_field("cache_kind", 32'(o_out_data.cache_kind), 32'(want.cache_kind));
                check_field("out_channel", 32'(o_out_data.out_channel),
                            32'(want.out_channel));
                check_field("block_min", 32'(o_out_data.block_min), 32'(want.block_min));
                check_field("block_max", 32'(o_out_data.block_max), 32'(want.block_max));
                check_field("abs_mean", 32'(o_out_data.abs_mean), 32'(want.abs_mean));
                check_field("last_out", 32'(o_out_data.last_out), 32'(want.last_out));
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    // Mostly short gaps, now and then a long one; none during calm stretches
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(25, 11);
    endfunction

    // Receiver stall pattern
    initial begin : out_stall_gen
        int n;
        i_out_stall = 1'b0;
        forever begin
            n = $urandom_range(20, 1);
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            n = pick_gap();
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
            end
        end
    end

    // Send one beat after a random gap; predict it once it is taken
    task automatic send_item(input t_in_item it);
        int                          gap;
        logic [31:0]                 r;
        logic [$bits(t_in_item)-1:0] noise;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            r          = $urandom;
            noise      = r[$bits(t_in_item)-1:0];
            i_in_valid = 1'b0;
            i_in_data  = noise;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = it;
        do @(posedge i_clk); while (o_in_stall);
        summarize_item(it);
    endtask

    // Hold input until every pending summary is out, then let the block settle
    task automatic wait_quiet();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_summaries.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_CHANNEL_COUNT: cfg_channels   = val[CNT_REG_W-1:0];
            REG_FINE_LEN:      cfg_fine_len   = val;
            REG_COARSE_LEN:    cfg_coarse_len = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] chans,
                             input logic [CFG_DATA_W-1:0] fine,
                             input logic [CFG_DATA_W-1:0] coarse);
        wait_quiet();
        write_reg(REG_CHANNEL_COUNT, chans);
        write_reg(REG_FINE_LEN, fine);
        write_reg(REG_COARSE_LEN, coarse);
    endtask

    function automatic t_in_item sample_beat(input int ch, input logic [SAMPLE_W-1:0] val);
        t_in_item it;
        it.req_type     = REQ_SAMPLE;
        it.sample_value = val;
        it.chan_index   = CH_W'(ch);
        return it;
    endfunction

    // Flush payload is don't-care, so fill it with noise
    function automatic t_in_item flush_beat();
        t_in_item    it;
        logic [31:0] r;
        r               = $urandom;
        it.req_type     = REQ_FLUSH;
        it.sample_value = r[SAMPLE_W-1:0];
        it.chan_index   = r[SAMPLE_W+CH_W-1:SAMPLE_W];
        return it;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return r[SAMPLE_W-1:0];
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings, sample extremes, ignored channel, flush of partial and empty blocks
    task automatic test_reset_settings();
        calm = 1'b1;
        send_item(sample_beat(0, 16'h7FFF));
        send_item(sample_beat(0, 16'h8000));
        send_item(sample_beat(0, 16'h0000));
        send_item(sample_beat(5, 16'h1234));
        calm = 1'b0;
        send_item(flush_beat());
        send_item(flush_beat());
        wait_quiet();
    endtask

    // Channel count and block length out of range, widest frame
    task automatic test_count_and_length_edges();
        // zero channels acts as one, zero length acts as one
        configure(16'hA000, 16'd0, 16'd1);
        send_item(sample_beat(0, 16'hFFFF));
        send_item(sample_beat(1, 16'h4000));
        // count of fifteen acts as eight
        configure(16'h5F0F, 16'd2, 16'hFFFF);
        write_reg(REG_SPARE, 16'hFFFF);
        for (int ch = 0; ch < MAX_CHANNELS; ch++)
            send_item(sample_beat(ch, ch[0] ? 16'h8000 : 16'h7FFF));
        send_item(sample_beat(MAX_CHANNELS - 1, 16'h0001));
        send_item(flush_beat());
        wait_quiet();
    endtask

    // Length lowered below the running count, flush with an unfinished frame
    task automatic test_lowered_length();
        configure(16'd2, 16'd4, 16'd4);
        send_item(sample_beat(1, 16'd100));
        send_item(sample_beat(1, -16'sd200));
        wait_quiet();
        write_reg(REG_FINE_LEN, 16'd1);
        send_item(sample_beat(0, 16'd300));
        send_item(sample_beat(1, 16'h8000));
        send_item(sample_beat(0, 16'd7));
        send_item(flush_beat());
        wait_quiet();
    endtask

    function automatic logic [CNT_REG_W-1:0] plan_channels(input int p);
        case (p)
            0:       return 4'd1;
            1:       return 4'd8;
            2:       return 4'd3;
            3:       return 4'd0;
            4:       return 4'd15;
            5:       return 4'd2;
            6:       return 4'd6;
            7:       return 4'd8;
            default: return CNT_REG_W'($urandom_range(8, 1));
        endcase
    endfunction

    // Mostly well-formed frames with random content, some stray channels and flushes
    task automatic test_random_stream();
        logic [CFG_DATA_W-1:0] chans;
        logic [CFG_DATA_W-1:0] fine;
        logic [CFG_DATA_W-1:0] coarse;
        int                    next_ch;
        int                    sel;
        for (int p = 0; p < N_PHASES; p++) begin
            chans = CFG_DATA_W'($urandom);
            chans[CNT_REG_W-1:0] = plan_channels(p);
            fine   = CFG_DATA_W'($urandom_range(5, 1));
            coarse = CFG_DATA_W'($urandom_range(8, 1));
            if (p == 3) begin
                fine   = 16'd0;
                coarse = 16'hFFFF;
            end else if (p == 7) begin
                fine   = 16'hFFFF;
                coarse = 16'd1;
            end
            configure(chans, fine, coarse);
            calm = (p == 2) || (p == 6);
            next_ch = 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                sel = $urandom_range(99);
                if (sel < 4) begin
                    send_item(flush_beat());
                    next_ch = 0;
                end else if (sel < 14) begin
                    send_item(sample_beat($urandom_range(MAX_CHANNELS - 1), pick_value()));
                end else begin
                    send_item(sample_beat(next_ch, pick_value()));
                    next_ch = (next_ch + 1) % live_channels();
                end
                // hold the sender mid-phase until the block has drained
                if (p == 4 && i == PHASE_ITEMS / 2) wait_quiet();
            end
            if ($urandom_range(1)) send_item(flush_beat());
            calm = 1'b0;
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_CHANNEL_COUNT;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        reset_summaries();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_settings();
        test_count_and_length_edges();
        test_lowered_length();
        test_random_stream();

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
rtl/core/wps_pkg.sv
rtl/core/wps_ctrl.sv
rtl/core/wps_datapath.sv
rtl/core/waveform_peak_summarizer.sv
bench/tb.sv
